/* design/sisq_pkg.sv */
package sisq_pkg;

   localparam int SISQ_QUEUE_DEPTH   = 64;
   localparam int SISQ_ID_BITS       = 16;
   localparam int SISQ_DURATION_BITS = 16;

   // fixed widths of the request and response fields
   localparam int FIELD_ID_W    = 16;
   localparam int FIELD_DUR_W   = 16;
   localparam int FIELD_POS_W   = 6;
   localparam int FIELD_LEVEL_W = 7;

   typedef enum logic [1:0] {
      OP_APPEND  = 2'd0,
      OP_SORTED  = 2'd1,
      OP_DEQUEUE = 2'd2,
      OP_SEARCH  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TAIL,
      ST_DEQ,
      ST_RESP
   } state_type;

endpackage

/* design/sisq_ram.sv */
module sisq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/sorted_insert_queue_with_search.sv */
// Bounded queue of (identifier, duration) entries held as a ring in one RAM with a
// single read and a single write port. start is taken when busy is low; the result
// is strobed on rsp_valid for one cycle and busy drops after that cycle. There is no
// way to hold a result off: the receiver cannot stall and must take the strobe as it
// comes. Append and the full, empty and empty-search cases go straight to ST_RESP;
// a dequeue reads in ST_DEQ first; a search walks ST_SCAN until a hit or the last
// entry, and a sorted insert walks every entry held in ST_SCAN, then writes ST_TAIL.
// The walk goes one entry per cycle through the single read port. A sorted insert reads
// ahead and writes back one place behind, carrying each displaced entry to the next slot.
module sorted_insert_queue_with_search
   import sisq_pkg::*;
#(
   parameter int QUEUE_DEPTH   = SISQ_QUEUE_DEPTH,
   parameter int ID_BITS       = SISQ_ID_BITS,
   parameter int DURATION_BITS = SISQ_DURATION_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_op,
   input  logic [FIELD_ID_W-1:0]    req_entry_id,
   input  logic [FIELD_DUR_W-1:0]   req_entry_duration,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_status,
   output logic [FIELD_ID_W-1:0]    rsp_out_id,
   output logic [FIELD_DUR_W-1:0]   rsp_out_duration,
   output logic [FIELD_POS_W-1:0]   rsp_found_position,
   output logic [FIELD_LEVEL_W-1:0] rsp_fill_level,
   output logic                     rsp_is_empty,
   output logic                     rsp_is_full
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int EW = ID_BITS + DURATION_BITS;

   state_type              state_ff, state_in;
   op_type                 op_ff, op_in;
   status_type             status_ff, status_in;
   logic [ID_BITS-1:0]     key_id_ff, key_id_in;
   logic [DURATION_BITS-1:0] key_dur_ff, key_dur_in;
   logic [EW-1:0]          carry_ff, carry_in;
   logic [EW-1:0]          out_ff, out_in;
   logic                   found_ff, found_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic [CW-1:0]          pos_ff, pos_in;
   logic [CW-1:0]          fill_ff, fill_in;
   logic [AW-1:0]          head_ff, head_in;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [EW-1:0]          wr_data;
   logic [CW-1:0]          rd_logical;
   logic [AW-1:0]          rd_addr;
   logic [EW-1:0]          rd_data;

   logic [ID_BITS-1:0]       req_id;
   logic [DURATION_BITS-1:0] req_dur;
   logic [ID_BITS-1:0]       rd_id;
   logic [DURATION_BITS-1:0] rd_dur;
   logic                     is_full, is_empty, scan_last, hit_id, hit_dur;

   // logical position from head to ring address
   function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] head,
                                               input logic [CW-1:0] lidx);
      logic [CW:0] sum;
      sum = (CW+1)'(head) + (CW+1)'(lidx);
      if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
         sum = sum - (CW+1)'(QUEUE_DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   sisq_ram #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_id    = ID_BITS'(req_entry_id);
   assign req_dur   = DURATION_BITS'(req_entry_duration);
   assign rd_id     = rd_data[EW-1:DURATION_BITS];
   assign rd_dur    = rd_data[DURATION_BITS-1:0];
   assign is_full   = (fill_ff == CW'(QUEUE_DEPTH));
   assign is_empty  = (fill_ff == '0);
   assign scan_last = ((idx_ff + CW'(1)) == fill_ff);
   assign hit_id    = (rd_id == key_id_ff);
   assign hit_dur   = (rd_dur >= key_dur_ff);
   assign op_in     = op_type'(req_op);
   assign rd_addr   = ring_addr(head_ff, rd_logical);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (op_in)
                  OP_APPEND:  state_in = ST_RESP;
                  OP_SORTED:  state_in = is_full ? ST_RESP : (is_empty ? ST_TAIL : ST_SCAN);
                  OP_DEQUEUE: state_in = is_empty ? ST_RESP : ST_DEQ;
                  OP_SEARCH:  state_in = is_empty ? ST_RESP : ST_SCAN;
               endcase
            end
         end
         ST_SCAN: begin
            if (op_ff == OP_SEARCH) begin
               if (hit_id || scan_last) state_in = ST_RESP;
            end else if (scan_last) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: state_in = ST_RESP;
         ST_DEQ:  state_in = ST_RESP;
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory port control
   always_comb begin
      key_id_in  = key_id_ff;
      key_dur_in = key_dur_ff;
      status_in  = status_ff;
      carry_in   = carry_ff;
      out_in     = out_ff;
      found_in   = found_ff;
      idx_in     = idx_ff;
      pos_in     = pos_ff;
      fill_in    = fill_ff;
      head_in    = head_ff;
      wr_en      = 1'b0;
      wr_addr    = ring_addr(head_ff, fill_ff);
      wr_data    = {key_id_ff, key_dur_ff};
      rd_logical = '0;
      unique case (state_ff)
         ST_IDLE: begin
            status_in  = STATUS_OK;
            out_in     = '0;
            pos_in     = '0;
            found_in   = 1'b0;
            idx_in     = '0;
            key_id_in  = req_id;
            key_dur_in = req_dur;
            if (start) begin
               unique case (op_in)
                  OP_APPEND: begin
                     if (is_full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_data = {req_id, req_dur};
                        fill_in = fill_ff + CW'(1);
                     end
                  end
                  OP_SORTED:  if (is_full) status_in = STATUS_FULL;
                  OP_DEQUEUE: if (is_empty) status_in = STATUS_EMPTY;
                  OP_SEARCH:  if (is_empty) status_in = STATUS_NOT_FOUND;
               endcase
            end
         end
         ST_SCAN: begin
            rd_logical = idx_ff + CW'(1);
            idx_in     = idx_ff + CW'(1);
            if (op_ff == OP_SEARCH) begin
               if (hit_id) begin
                  pos_in = idx_ff;
               end else if (scan_last) begin
                  status_in = STATUS_NOT_FOUND;
               end
            end else if (found_ff || hit_dur) begin
               // place the new entry or the carried one, pick up the displaced one
               wr_en    = 1'b1;
               wr_addr  = ring_addr(head_ff, idx_ff);
               wr_data  = found_ff ? carry_ff : {key_id_ff, key_dur_ff};
               carry_in = rd_data;
               found_in = 1'b1;
            end
         end
         ST_TAIL: begin
            wr_en   = 1'b1;
            wr_data = found_ff ? carry_ff : {key_id_ff, key_dur_ff};
            fill_in = fill_ff + CW'(1);
         end
         ST_DEQ: begin
            out_in  = rd_data;
            head_in = (head_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + AW'(1);
            fill_in = fill_ff - CW'(1);
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         head_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         head_ff  <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         op_ff <= op_in;
      end
      key_id_ff  <= key_id_in;
      key_dur_ff <= key_dur_in;
      status_ff  <= status_in;
      carry_ff   <= carry_in;
      out_ff     <= out_in;
      found_ff   <= found_in;
      idx_ff     <= idx_in;
      pos_ff     <= pos_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = (state_ff == ST_RESP);
   assign rsp_status         = status_ff;
   assign rsp_out_id         = FIELD_ID_W'(out_ff[EW-1:DURATION_BITS]);
   assign rsp_out_duration   = FIELD_DUR_W'(out_ff[DURATION_BITS-1:0]);
   assign rsp_found_position = FIELD_POS_W'(pos_ff);
   assign rsp_fill_level     = FIELD_LEVEL_W'(fill_ff);
   assign rsp_is_empty       = is_empty;
   assign rsp_is_full        = is_full;

   // one strobe per transaction, then back to idle
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(QUEUE_DEPTH))
      else $error("fill count beyond capacity");

   a_dequeue_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DEQ) |=> ((fill_ff + CW'(1)) == $past(fill_ff)))
      else $error("dequeue did not lower the fill count by one");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb
   import sisq_pkg::*;
;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PRINT_LIMIT = 50;

   typedef struct packed {
      logic [FIELD_ID_W-1:0]  id;
      logic [FIELD_DUR_W-1:0] dur;
   } entry_type;

   typedef struct packed {
      status_type               status;
      logic [FIELD_ID_W-1:0]    out_id;
      logic [FIELD_DUR_W-1:0]   out_dur;
      logic [FIELD_POS_W-1:0]   pos;
      logic [FIELD_LEVEL_W-1:0] level;
      logic                     empty;
      logic                     full;
   } response_type;

   class queue_tracker;
      entry_type    held_entries[$];
      response_type awaited[$];
      int errors, requests, responses;
      int full_rejects, empty_dequeues, search_hits, search_misses;

      // apply one accepted request to the shadow queue and queue up its response
      function void note_request(op_type op, logic [FIELD_ID_W-1:0] id,
                                 logic [FIELD_DUR_W-1:0] dur);
         response_type r;
         entry_type    e;
         int           k;
         r = '0;
         r.status = STATUS_OK;
         e.id = id;
         e.dur = dur;
         requests++;
         case (op) inside
            OP_APPEND, OP_SORTED: begin
               if (held_entries.size() >= SISQ_QUEUE_DEPTH) begin
                  r.status = STATUS_FULL;
                  full_rejects++;
               end else begin
                  k = held_entries.size();
                  if (op == OP_SORTED) begin
                     // goes ahead of entries with equal duration
                     k = 0;
                     while (k < held_entries.size() && held_entries[k].dur < dur) k++;
                  end
                  held_entries.insert(k, e);
               end
            end
            OP_DEQUEUE: begin
               if (held_entries.size() == 0) begin
                  r.status = STATUS_EMPTY;
                  empty_dequeues++;
               end else begin
                  e = held_entries.pop_front();
                  r.out_id = e.id;
                  r.out_dur = e.dur;
               end
            end
            default: begin
               r.status = STATUS_NOT_FOUND;
               for (k = 0; k < held_entries.size(); k++) begin
                  if (held_entries[k].id == id) begin
                     r.status = STATUS_OK;
                     r.pos = FIELD_POS_W'(k);
                     break;
                  end
               end
               if (r.status == STATUS_OK) search_hits++;
               else search_misses++;
            end
         endcase
         r.level = FIELD_LEVEL_W'(held_entries.size());
         r.empty = (held_entries.size() == 0);
         r.full = (held_entries.size() == SISQ_QUEUE_DEPTH);
         awaited.push_back(r);
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         if (errors <= PRINT_LIMIT)
            $display("error: response %0d %s: got %h, expected %h", responses, what, got, want);
      endtask

      task check_response(logic [1:0] status, logic [FIELD_ID_W-1:0] out_id,
                          logic [FIELD_DUR_W-1:0] out_dur, logic [FIELD_POS_W-1:0] pos,
                          logic [FIELD_LEVEL_W-1:0] level, logic empty, logic full);
         response_type w;
         responses++;
         if (awaited.size() == 0) begin
            report_mismatch("arrived with no request outstanding", 32'(status), '0);
         end else begin
            w = awaited.pop_front();
            if (status !== w.status) report_mismatch("status", 32'(status), 32'(w.status));
            if (out_id !== w.out_id) report_mismatch("out_id", 32'(out_id), 32'(w.out_id));
            if (out_dur !== w.out_dur)
               report_mismatch("out_duration", 32'(out_dur), 32'(w.out_dur));
            if (pos !== w.pos) report_mismatch("found_position", 32'(pos), 32'(w.pos));
            if (level !== w.level) report_mismatch("fill_level", 32'(level), 32'(w.level));
            if (empty !== w.empty) report_mismatch("is_empty", 32'(empty), 32'(w.empty));
            if (full !== w.full) report_mismatch("is_full", 32'(full), 32'(w.full));
         end
      endtask
   endclass

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [1:0]               req_op = OP_APPEND;
   logic [FIELD_ID_W-1:0]    req_entry_id = '0;
   logic [FIELD_DUR_W-1:0]   req_entry_duration = '0;
   logic                     rsp_valid;
   logic [1:0]               rsp_status;
   logic [FIELD_ID_W-1:0]    rsp_out_id;
   logic [FIELD_DUR_W-1:0]   rsp_out_duration;
   logic [FIELD_POS_W-1:0]   rsp_found_position;
   logic [FIELD_LEVEL_W-1:0] rsp_fill_level;
   logic                     rsp_is_empty;
   logic                     rsp_is_full;

   queue_tracker tracker = new;
   int           idle_pct = 0;
   int           cycles = 0;

   sorted_insert_queue_with_search dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_op),
      .req_entry_id       (req_entry_id),
      .req_entry_duration (req_entry_duration),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_out_id         (rsp_out_id),
      .rsp_out_duration   (rsp_out_duration),
      .rsp_found_position (rsp_found_position),
      .rsp_fill_level     (rsp_fill_level),
      .rsp_is_empty       (rsp_is_empty),
      .rsp_is_full        (rsp_is_full)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycles,
                  tracker.awaited.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // response first: a response never belongs to a transaction taken on the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            tracker.check_response(rsp_status, rsp_out_id, rsp_out_duration,
                                   rsp_found_position, rsp_fill_level, rsp_is_empty,
                                   rsp_is_full);
         if (start && !busy)
            tracker.note_request(op_type'(req_op), req_entry_id, req_entry_duration);
      end
   end

   // returns at the edge that takes the transaction
   task automatic send(op_type op, logic [FIELD_ID_W-1:0] id, logic [FIELD_DUR_W-1:0] dur);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_op <= op;
      req_entry_id <= id;
      req_entry_duration <= dur;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // the first negedge lets the monitor note a transaction taken on the last edge
   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (tracker.awaited.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   initial begin
      int         phase_idle[4];
      int         pick;
      int         n;
      int         phase;
      bit         growing;
      op_type     op;
      logic [FIELD_ID_W-1:0]  id;
      logic [FIELD_DUR_W-1:0] dur;

      // the receiver cannot stall, so only the sender is paced; two phases run back to back
      phase_idle = '{0, 47, 0, 25};
      growing = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send(OP_SEARCH, 16'd5, 16'd0);
      send(OP_DEQUEUE, 16'd0, 16'd0);
      send(OP_APPEND, 16'd1, 16'd100);
      send(OP_APPEND, 16'hFFFF, 16'hFFFF);
      send(OP_SORTED, 16'd2, 16'd0);
      send(OP_SORTED, 16'd3, 16'd100);
      send(OP_SORTED, 16'd4, 16'hFFFF);
      send(OP_SORTED, 16'd5, 16'd50);
      send(OP_SEARCH, 16'hFFFF, 16'hFFFF);
      send(OP_SEARCH, 16'd2, 16'd0);
      send(OP_SEARCH, 16'd1234, 16'h5555);
      send(OP_APPEND, 16'd0, 16'd0);
      send(OP_SEARCH, 16'd0, 16'hAAAA);
      send(OP_DEQUEUE, 16'hFFFF, 16'hFFFF);
      send(OP_DEQUEUE, 16'd0, 16'd0);
      send(OP_SORTED, 16'd6, 16'd0);
      send(OP_DEQUEUE, 16'd0, 16'd0);
      drain();

      for (phase = 0; phase < 4; phase++) begin
         idle_pct = phase_idle[phase];
         for (n = 0; n < 100; n++) begin
            // swing between filling up to full and draining down to empty
            if (growing && tracker.held_entries.size() == SISQ_QUEUE_DEPTH &&
                $urandom_range(2) == 0)
               growing = 1'b0;
            else if (!growing && tracker.held_entries.size() == 0 && $urandom_range(2) == 0)
               growing = 1'b1;
            pick = $urandom_range(99);
            if (growing)
               op = (pick < 35) ? OP_APPEND : (pick < 75) ? OP_SORTED :
                    (pick < 85) ? OP_DEQUEUE : OP_SEARCH;
            else
               op = (pick < 10) ? OP_APPEND : (pick < 20) ? OP_SORTED :
                    (pick < 80) ? OP_DEQUEUE : OP_SEARCH;
            // a small id pool makes searches hit, a small duration pool makes ties
            pick = $urandom_range(9);
            if (pick < 5) id = FIELD_ID_W'($urandom_range(15));
            else if (pick == 5) id = '1;
            else if (pick == 6) id = '0;
            else id = FIELD_ID_W'($urandom);
            pick = $urandom_range(9);
            if (pick < 4) dur = FIELD_DUR_W'($urandom_range(7));
            else if (pick == 4) dur = '1;
            else if (pick == 5) dur = '0;
            else dur = FIELD_DUR_W'($urandom);
            send(op, id, dur);
         end
         drain();
      end

      repeat (SISQ_QUEUE_DEPTH + 8) @(posedge clock);
      if (tracker.awaited.size() != 0)
         tracker.report_mismatch("left outstanding at end", 32'(tracker.awaited.size()), '0);

      $display("%0d transactions sent, %0d responses checked, four sender pacing phases",
               tracker.requests, tracker.responses);
      $display("full rejects %0d, empty dequeues %0d, search hits %0d, search misses %0d",
               tracker.full_rejects, tracker.empty_dequeues, tracker.search_hits,
               tracker.search_misses);
      if (tracker.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", tracker.errors);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
